// ===== rtl/firlp_pkg.sv =====
// ----------------------------------------------------------------------------
// firlp_pkg
// Shared types, constants and the coefficient ROM of the 64-tap low-pass FIR.
// ----------------------------------------------------------------------------
package firlp_pkg;

  localparam int unsigned Taps       = 64;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned CoefBits   = 16;

  localparam int unsigned RomTaps = 64;
  localparam int unsigned RomIdxW = 6;
  localparam int unsigned RomFrac = 15;

  // Hamming-window low-pass, 1 kHz cutoff at 9615 Hz sampling, Q1.15.
  localparam logic signed [15:0] RomTable [RomTaps] = '{
       16'sd25,    16'sd30,    16'sd23,     16'sd4,   -16'sd24,   -16'sd51,   -16'sd63,
      -16'sd47,     16'sd2,    16'sd72,   16'sd134,   16'sd149,    16'sd93,   -16'sd34,
     -16'sd190,  -16'sd304,  -16'sd304,  -16'sd151,   16'sd128,   16'sd435,   16'sd624,
      16'sd566,   16'sd207,  -16'sd378,  -16'sd983, -16'sd1323, -16'sd1128,  -16'sd248,
     16'sd1267,  16'sd3153,  16'sd4991,  16'sd6327,  16'sd6816,  16'sd6327,  16'sd4991,
     16'sd3153,  16'sd1267,  -16'sd248, -16'sd1128, -16'sd1323,  -16'sd983,  -16'sd378,
      16'sd207,   16'sd566,   16'sd624,   16'sd435,   16'sd128,  -16'sd151,  -16'sd304,
     -16'sd304,  -16'sd190,   -16'sd34,    16'sd93,   16'sd149,   16'sd134,    16'sd72,
       16'sd2,    -16'sd47,   -16'sd63,   -16'sd51,   -16'sd24,     16'sd4,    16'sd23,
      16'sd30
  };

  typedef struct packed {
    logic load;
    logic rotate;
  } chain_ctrl_t;

  // Coefficient of tap k scaled to cb bits with cb-1 fraction bits.
  function automatic logic signed [31:0] coef_at(input int unsigned k,
                                                 input int unsigned cb);
    logic [31:0]        kk;
    logic signed [31:0] c;
    logic signed [31:0] r;
    kk = k;
    r  = '0;
    if (kk < RomTaps) begin
      c = 32'(RomTable[kk[RomIdxW-1:0]]);
      if (cb >= RomFrac + 1) begin
        r = c <<< (cb - (RomFrac + 1));
      end else begin
        r = (c + (32'sd1 <<< (RomFrac - cb))) >>> ((RomFrac + 1) - cb);
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/firlp_cell.sv =====
// ----------------------------------------------------------------------------
// firlp_cell
// One history cell: takes a new sample from its left neighbor on a load and
// the sample of its right neighbor on a rotate.
// ----------------------------------------------------------------------------
module firlp_cell #(
  parameter int unsigned SampleBits = firlp_pkg::SampleBits
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  firlp_pkg::chain_ctrl_t      ctrl_i,
  input  logic signed [SampleBits-1:0] left_i,
  input  logic signed [SampleBits-1:0] right_i,
  output logic signed [SampleBits-1:0] data_o
);

  logic signed [SampleBits-1:0] data_q;
  logic signed [SampleBits-1:0] data_d;

  always_comb begin
    data_d = data_q;
    if (ctrl_i.load) begin
      data_d = left_i;
    end else if (ctrl_i.rotate) begin
      data_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

// ===== rtl/firlp_mac.sv =====
// ----------------------------------------------------------------------------
// firlp_mac
// Tap sequencer and shared multiply-accumulate with rounding, saturation and
// the output register.
// ----------------------------------------------------------------------------
module firlp_mac #(
  parameter int unsigned Taps       = firlp_pkg::Taps,
  parameter int unsigned SampleBits = firlp_pkg::SampleBits,
  parameter int unsigned CoefBits   = firlp_pkg::CoefBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [SampleBits-1:0] tap_i,
  output firlp_pkg::chain_ctrl_t       ctrl_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [SampleBits-1:0] filtered_sample_o
);

  localparam int unsigned CntW  = $clog2(Taps);
  localparam int unsigned ProdW = SampleBits + CoefBits;
  localparam int unsigned AccW  = ProdW + $clog2(Taps) + 1;
  localparam logic signed [AccW-1:0] SMax = (AccW'(1) <<< (SampleBits - 1)) - AccW'(1);
  localparam logic signed [AccW-1:0] SMin = -SMax - AccW'(1);
  localparam logic signed [AccW-1:0] RndHalf = AccW'(1) <<< (CoefBits - 2);

  logic                         accept;
  logic                         last_tap;
  logic                         out_load;
  logic                         busy_q, busy_d;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic signed [ProdW-1:0]      prod_q, prod_d;
  logic                         prod_v_q, prod_v_d;
  logic                         prod_last_q, prod_last_d;
  logic signed [AccW-1:0]       acc_q, acc_d;
  logic                         fin_q, fin_d;
  logic                         out_valid_q, out_valid_d;
  logic signed [SampleBits-1:0] out_data_q, out_data_d;
  logic signed [CoefBits-1:0]   coef;
  logic signed [31:0]           coef_word;
  logic signed [AccW-1:0]       rnd_sum;
  logic signed [AccW-1:0]       rnd_shift;

  assign in_stall_o = busy_q | prod_v_q | fin_q;
  assign accept     = in_valid_i & ~in_stall_o;
  assign last_tap   = busy_q & (cnt_q == CntW'(Taps - 1));
  assign out_load   = fin_q & (~out_valid_q | ~out_stall_i);

  assign ctrl_o.load   = accept;
  assign ctrl_o.rotate = busy_q;

  assign coef_word = firlp_pkg::coef_at(int'(cnt_q), CoefBits);
  assign coef      = coef_word[CoefBits-1:0];
  assign prod_d    = ProdW'(tap_i) * ProdW'(coef);

  assign rnd_sum   = acc_q + RndHalf;
  assign rnd_shift = rnd_sum >>> (CoefBits - 1);

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    prod_v_d    = busy_q;
    prod_last_d = last_tap;
    acc_d       = acc_q;
    fin_d       = fin_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (accept) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CntW'(1);
      if (last_tap) begin
        busy_d = 1'b0;
      end
    end

    if (prod_v_q) begin
      acc_d = acc_q + AccW'(prod_q);
      if (prod_last_q) begin
        fin_d = 1'b1;
      end
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      fin_d       = 1'b0;
      out_valid_d = 1'b1;
      if (rnd_shift > SMax) begin
        out_data_d = SMax[SampleBits-1:0];
      end else if (rnd_shift < SMin) begin
        out_data_d = SMin[SampleBits-1:0];
      end else begin
        out_data_d = rnd_shift[SampleBits-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      prod_v_q    <= 1'b0;
      prod_last_q <= 1'b0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      prod_v_q    <= prod_v_d;
      prod_last_q <= prod_last_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o       = out_valid_q;
  assign filtered_sample_o = out_data_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q && cnt_q == '0)
    else $error("accepted transaction did not start the tap sweep");

  a_last_tap_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_tap |=> !busy_q && prod_v_q && prod_last_q)
    else $error("tap sweep did not end after the last tap");

  a_fin_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> !busy_q && !prod_v_q)
    else $error("result finished while the sweep is still running");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fin_q))
    else $error("output appeared without a finished accumulation");

endmodule

// ===== rtl/fir_lowpass_64tap_unit.sv =====
// ----------------------------------------------------------------------------
// Each result passes the product register, accumulator and output register.
// The input stalls until the previous result is in the output register, since
// one shared multiply-accumulate visits one tap per cycle as history rotates.
// Reset clears the sample history to zeros and empties the pipeline.
// ----------------------------------------------------------------------------
// fir_lowpass_64tap_unit
// Direct-form low-pass FIR: a rotating chain of history cells feeds one
// multiply-accumulate; the result is rounded and saturated to the sample width.
// ----------------------------------------------------------------------------
module fir_lowpass_64tap_unit #(
  parameter int unsigned Taps       = firlp_pkg::Taps,
  parameter int unsigned SampleBits = firlp_pkg::SampleBits,
  parameter int unsigned CoefBits   = firlp_pkg::CoefBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [SampleBits-1:0] sample_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [SampleBits-1:0] filtered_sample_o
);

  firlp_pkg::chain_ctrl_t       ctrl;
  logic signed [SampleBits-1:0] cell_data [Taps];

  for (genvar k = 0; k < Taps; k++) begin : g_cell
    logic signed [SampleBits-1:0] left;
    if (k == 0) begin : g_head
      assign left = sample_in_i;
    end else begin : g_body
      assign left = cell_data[k-1];
    end

    firlp_cell #(
      .SampleBits(SampleBits)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .left_i (left),
      .right_i(cell_data[(k + 1) % Taps]),
      .data_o (cell_data[k])
    );
  end

  firlp_mac #(
    .Taps      (Taps),
    .SampleBits(SampleBits),
    .CoefBits  (CoefBits)
  ) u_mac (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .tap_i            (cell_data[0]),
    .ctrl_o           (ctrl),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .filtered_sample_o(filtered_sample_o)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench of the 64-tap low-pass FIR unit
// Samples are pushed through the valid/stall input channel. Each sample that
// is taken is run through a local filter model, and the filtered sample it
// should give is queued. Every output transaction is checked against the
// oldest queued value. The run covers full-scale steps and impulses,
// sign-matched patterns that drive the output into saturation, and random
// samples. Both channels idle at random, and the output is held off for a
// long stretch so that the input backs up.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned Taps       = firlp_pkg::Taps;
  localparam int unsigned SampleBits = firlp_pkg::SampleBits;
  localparam int unsigned CoefBits   = firlp_pkg::CoefBits;
  localparam int unsigned RomTaps    = firlp_pkg::RomTaps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 500;
  localparam int unsigned DrainWait  = 100;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic signed [SampleBits-1:0] sample_in = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [SampleBits-1:0] filtered_sample;

  logic signed [SampleBits-1:0] pending_samples[$];
  logic signed [SampleBits-1:0] expected_outputs[$];

  logic signed [SampleBits-1:0] tap_history [Taps];
  int unsigned                  next_slot = 0;

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  logic        hold_on = 1'b0;
  int unsigned hold_count = 0;
  logic        in_taken = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  fir_lowpass_64tap_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .sample_in_i      (sample_in),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .filtered_sample_o(filtered_sample)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Writes the sample into the history and returns the rounded, saturated sum.
  function automatic logic signed [SampleBits-1:0] filter_next(
      input logic signed [SampleBits-1:0] x);
    longint      acc;
    longint      y;
    int unsigned idx;
    longint      smax;
    longint      smin;
    smax = (64'sd1 <<< (SampleBits - 1)) - 1;
    smin = -smax - 1;
    tap_history[next_slot] = x;
    next_slot = (next_slot + 1) % Taps;
    idx = next_slot;
    acc = 0;
    for (int unsigned k = 0; k < Taps; k++) begin
      idx = (idx == 0) ? Taps - 1 : idx - 1;
      if (k < RomTaps) begin
        acc += longint'(firlp_pkg::RomTable[k]) * longint'(tap_history[idx]);
      end
    end
    y = (acc + (64'sd1 <<< (CoefBits - 2))) >>> (CoefBits - 1);
    if (y > smax) begin
      y = smax;
    end
    if (y < smin) begin
      y = smin;
    end
    return y[SampleBits-1:0];
  endfunction

  function automatic logic signed [SampleBits-1:0] random_sample();
    int unsigned pick;
    logic [31:0] r;
    pick = $urandom_range(99);
    r = $urandom;
    if (pick < 70) begin
      return r[SampleBits-1:0];
    end else if (pick < 85) begin
      return r[0] ? 16'sh7fff : 16'sh8000;
    end else begin
      return SampleBits'($signed(r[5:0]) - 32);
    end
  endfunction

  // A window of near full-scale samples whose signs follow the taps, so that
  // the sum lands on or near the clamp.
  task automatic queue_saturating(input bit positive);
    int v;
    for (int j = 0; j < RomTaps; j++) begin
      v = $urandom_range(32767, 24000);
      if ((firlp_pkg::RomTable[RomTaps-1-j] > 0) != positive) begin
        v = -v - 1;
      end
      pending_samples.push_back(SampleBits'(v));
    end
  endtask

  task automatic queue_random_mix(input int unsigned n_items);
    int unsigned added;
    int unsigned len;
    logic signed [SampleBits-1:0] level;
    added = 0;
    while (added < n_items) begin
      case ($urandom_range(15))
        0: begin
          queue_saturating(1'b1);
          added += RomTaps;
        end
        1: begin
          queue_saturating(1'b0);
          added += RomTaps;
        end
        2: begin
          len = $urandom_range(12, 2);
          pending_samples.push_back(random_sample());
          for (int unsigned i = 1; i < len; i++) begin
            pending_samples.push_back('0);
          end
          added += len;
        end
        3: begin
          len = $urandom_range(70, 1);
          level = random_sample();
          for (int unsigned i = 0; i < len; i++) begin
            pending_samples.push_back(level);
          end
          added += len;
        end
        default: begin
          len = $urandom_range(16, 1);
          for (int unsigned i = 0; i < len; i++) begin
            pending_samples.push_back(random_sample());
          end
          added += len;
        end
      endcase
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk_i);
    end while (pending_samples.size() != 0 || in_valid || expected_outputs.size() != 0);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid  <= 1'b1;
        sample_in <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_on && hold_count < HoldCycles) begin
      out_stall  <= 1'b1;
      hold_count <= hold_count + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
      if (!hold_on) begin
        hold_count <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    logic signed [SampleBits-1:0] want;
    in_taken <= rst_ni && in_valid && !in_stall;
    if (rst_ni && in_valid && !in_stall) begin
      expected_outputs.push_back(filter_next(sample_in));
    end
    if (rst_ni && out_valid && !out_stall) begin
      if (expected_outputs.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected transaction, expected none, actual %0d", $time,
                 filtered_sample);
      end else begin
        want = expected_outputs.pop_front();
        if (filtered_sample !== want) begin
          mismatch_count++;
          $display("%0t: filtered_sample mismatch, expected %0d, actual %0d", $time, want,
                   filtered_sample);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    for (int unsigned i = 0; i < Taps; i++) begin
      tap_history[i] = '0;
    end
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    send_idle_pct = 27;
    recv_idle_pct = 70;
    pending_samples.push_back('0);
    pending_samples.push_back(16'sh7fff);
    pending_samples.push_back(16'sh8000);
    pending_samples.push_back(-16'sd1);
    pending_samples.push_back(16'sd1);
    pending_samples.push_back(16'sh7fff);
    repeat (8) pending_samples.push_back('0);
    pending_samples.push_back(16'sh8000);
    repeat (8) pending_samples.push_back('0);
    queue_random_mix(230);
    wait_drained();

    send_idle_pct = 70;
    recv_idle_pct = 27;
    queue_random_mix(230);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_on = 1'b1;
    repeat (20) pending_samples.push_back(random_sample());
    while (hold_count < HoldCycles) begin
      @(posedge clk_i);
    end
    hold_on = 1'b0;
    wait_drained();
    queue_random_mix(220);
    wait_drained();
    repeat (DrainWait) @(posedge clk_i);

    if (mismatch_count == 0 && expected_outputs.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
